// ===== rtl/core/psds_pkg.sv =====
// shared constants and codes for the particle sphere distance splat block
`default_nettype none
package psds_pkg;

   localparam int DEF_BLOCK_WIDTH    = 8;
   localparam int DEF_CELL_FRAC_BITS = 8;

   localparam int POS_W    = 16;
   localparam int DIST_W   = 16;
   localparam int CMD_W    = 2;
   localparam int CELL_W   = 9;
   localparam int CSR_W    = 12;
   localparam int CSR_AW   = 1;
   localparam int REQ_W    = 64;
   localparam int RSP_W    = 32;

   localparam logic [CSR_W-1:0] RADIUS_RESET = 12'd256;
   localparam logic [CSR_W-1:0] SEARCH_RESET = 12'd512;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SPLAT = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_PARTICLE_RADIUS = 1'b0,
      REG_SEARCH_RADIUS   = 1'b1
   } reg_index_type;

endpackage
`default_nettype wire

// ===== rtl/core/particle_sphere_distance_splat_top.sv =====
// top level of the particle sphere distance splat block
`default_nettype none
// Holds a cube of BLOCK_WIDTH^3 signed Q(F) distance cells in one synchronous memory.
// A clear command sweeps the memory one cell a cycle; the same sweep runs after reset,
// and no transfer is taken during it. A splat visits every cell of the clipped search
// box, one at a time: three subtract/multiply/accumulate steps on one shared multiplier,
// a one-bit per cycle square root, rounding, saturation and a read-min-write of the
// cell. A read passes through a memory read state and an output state, where it waits
// until the result register is free or being emptied. An empty box returns to idle
// straight from the box state; an unknown command or an out-of-range read is dropped
// in the cycle it is taken, so the next transfer can follow at once. Configuration
// writes belong between commands, while the block is idle; a splat uses the particle
// radius live on every cell it visits.
module particle_sphere_distance_splat_top
   import psds_pkg::*;
#(
   parameter int BLOCK_WIDTH    = DEF_BLOCK_WIDTH,
   parameter int CELL_FRAC_BITS = DEF_CELL_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   // command[1:0], pos_x[17:2], pos_y[33:18], pos_z[49:34], read_cell[58:50], zero pad
   input  wire logic [REQ_W-1:0]  req_tdata,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   // cell_number[8:0], distance[24:9], zero pad
   output      logic [RSP_W-1:0]  rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int F     = CELL_FRAC_BITS;
   localparam int NC    = BLOCK_WIDTH * BLOCK_WIDTH * BLOCK_WIDTH;
   localparam int AW    = $clog2(NC);
   localparam int IW    = $clog2(BLOCK_WIDTH);
   localparam int CW    = IW + F;
   localparam int DW    = ((CW > POS_W) ? CW : POS_W) + 2;   // signed axis difference
   localparam int SUMW  = 2 * DW + 2;                         // sum of squares, even
   localparam int NIT   = SUMW / 2;
   localparam int ITW   = $clog2(NIT + 1);
   localparam int BW    = POS_W + 2;                          // box edge arithmetic
   localparam int DLW   = SUMW + 2;                           // signed distance before clip
   localparam logic [F-1:0]      HALF_F = F'(1) << (F - 1);
   localparam logic [DIST_W-1:0] FAR_D  = DIST_W'(3) << F;
   localparam logic [AW-1:0]     LAST_A = AW'(NC - 1);
   localparam logic [IW-1:0]     LAST_I = IW'(BLOCK_WIDTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_RD_MEM, S_RD_OUT, S_BOX, S_DIFF, S_MULT, S_ACC,
      S_SQRT, S_ROUND, S_DIST, S_CMP
   } state_type;

   state_type state_ff;

   // configuration
   logic [CSR_W-1:0] radius_ff, search_ff;

   // latched request
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   logic [CELL_W-1:0]       cell_ff;

   // box and walk
   logic [IW-1:0] lox_ff, hix_ff, loy_ff, hiy_ff, loz_ff, hiz_ff;
   logic [IW-1:0] i_ff, j_ff, k_ff;
   logic [1:0]    ax_ff;
   logic [AW-1:0] clr_ff;

   // arithmetic
   logic signed [DW-1:0]     diff_ff;
   logic [2*DW-1:0]          sq_ff;
   logic [SUMW-1:0]          acc_ff, root_ff, bit_ff;
   logic [ITW-1:0]           it_ff;
   logic signed [DIST_W-1:0] dist_ff;

   // memory
   logic [DIST_W-1:0] mem [NC];
   logic [DIST_W-1:0] rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   logic [DIST_W-1:0] mem_wdata;

   // output register
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - CELL_W - DIST_W){1'b0}}, rsp_dist_ff, rsp_cell_ff};

   // read result goes out once the register is free or being emptied
   assign rsp_load = (state_ff == S_RD_OUT) && (!rsp_valid_ff || rsp_tready);

   // request fields
   logic [CMD_W-1:0]        req_cmd;
   logic signed [POS_W-1:0] req_x, req_y, req_z;
   logic [CELL_W-1:0]       req_cell;
   assign req_cmd  = req_tdata[1:0];
   assign req_x    = req_tdata[17:2];
   assign req_y    = req_tdata[33:18];
   assign req_z    = req_tdata[49:34];
   assign req_cell = req_tdata[58:50];

   // flat cell index of the walk
   logic [AW-1:0] cell_idx;
   assign cell_idx = AW'(i_ff) + AW'(AW'(j_ff) * AW'(BLOCK_WIDTH))
                   + AW'(AW'(k_ff) * AW'(BLOCK_WIDTH * BLOCK_WIDTH));

   // search box per axis: floor((p -/+ search) / 2^F), clipped
   logic signed [BW-1:0] lo_raw [3];
   logic signed [BW-1:0] hi_raw [3];
   logic [IW-1:0]        lo_clip [3];
   logic [IW-1:0]        hi_clip [3];
   logic                 box_empty;
   always_comb begin
      logic signed [BW-1:0] p [3];
      logic signed [BW-1:0] sr;
      p[0] = BW'(px_ff);
      p[1] = BW'(py_ff);
      p[2] = BW'(pz_ff);
      sr = signed'(BW'(search_ff));
      box_empty = 1'b0;
      for (int a = 0; a < 3; a++) begin
         lo_raw[a] = (p[a] - sr) >>> F;
         hi_raw[a] = (p[a] + sr) >>> F;
         lo_clip[a] = (lo_raw[a] < 0) ? '0 : IW'(lo_raw[a]);
         hi_clip[a] = (hi_raw[a] > BW'(BLOCK_WIDTH - 1)) ? LAST_I : IW'(hi_raw[a]);
         if (lo_raw[a] > BW'(BLOCK_WIDTH - 1) || hi_raw[a] < 0 || lo_raw[a] > hi_raw[a])
            box_empty = 1'b1;
      end
   end

   // axis difference: cell centre minus particle
   logic [IW-1:0]           ax_idx;
   logic signed [POS_W-1:0] ax_pos;
   logic signed [DW-1:0]    diff_in;
   always_comb begin
      case (ax_ff)
         2'd0:    begin ax_idx = i_ff; ax_pos = px_ff; end
         2'd1:    begin ax_idx = j_ff; ax_pos = py_ff; end
         default: begin ax_idx = k_ff; ax_pos = pz_ff; end
      endcase
      diff_in = signed'(DW'({ax_idx, HALF_F})) - DW'(ax_pos);
   end

   logic signed [2*DW-1:0] sq_in;
   assign sq_in = diff_ff * diff_ff;

   // one step of the square root
   logic [SUMW-1:0] trial;
   assign trial = root_ff + bit_ff;

   // distance with saturation
   logic signed [DLW-1:0]    dl;
   logic signed [DIST_W-1:0] dist_in;
   always_comb begin
      dl = signed'(DLW'(root_ff)) - signed'(DLW'(radius_ff));
      if (dl > DLW'(32767))
         dist_in = 16'sh7fff;
      else if (dl < -DLW'(32768))
         dist_in = 16'sh8000;
      else
         dist_in = DIST_W'(dl);
   end

   // memory port control
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = cell_idx;
      mem_we    = 1'b0;
      mem_waddr = cell_idx;
      mem_wdata = dist_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = FAR_D;
         end
         S_RD_MEM: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(cell_ff);
         end
         S_DIST: begin
            mem_re = 1'b1;
         end
         S_CMP: begin
            mem_we = (dist_ff < signed'(rd_data_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         rd_data_ff <= mem[mem_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         search_ff <= SEARCH_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_PARTICLE_RADIUS: radius_ff <= csr_wdata;
            REG_SEARCH_RADIUS:   search_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  px_ff   <= req_x;
                  py_ff   <= req_y;
                  pz_ff   <= req_z;
                  cell_ff <= req_cell;
                  clr_ff  <= '0;
                  case (cmd_type'(req_cmd))
                     CMD_CLEAR: state_ff <= S_CLEAR;
                     CMD_SPLAT: state_ff <= S_BOX;
                     CMD_READ: begin
                        if (32'(req_cell) < NC)
                           state_ff <= S_RD_MEM;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_A)
                  state_ff <= S_IDLE;
            end
            S_RD_MEM: state_ff <= S_RD_OUT;
            S_RD_OUT: begin
               if (rsp_load) begin
                  rsp_cell_ff  <= cell_ff;
                  rsp_dist_ff  <= rd_data_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_BOX: begin
               lox_ff <= lo_clip[0]; hix_ff <= hi_clip[0];
               loy_ff <= lo_clip[1]; hiy_ff <= hi_clip[1];
               loz_ff <= lo_clip[2]; hiz_ff <= hi_clip[2];
               i_ff   <= lo_clip[0];
               j_ff   <= lo_clip[1];
               k_ff   <= lo_clip[2];
               ax_ff  <= 2'd0;
               acc_ff <= '0;
               state_ff <= box_empty ? S_IDLE : S_DIFF;
            end
            S_DIFF: begin
               diff_ff  <= diff_in;
               state_ff <= S_MULT;
            end
            S_MULT: begin
               sq_ff    <= unsigned'(sq_in);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= acc_ff + SUMW'(sq_ff);
               if (ax_ff == 2'd2) begin
                  root_ff  <= '0;
                  bit_ff   <= SUMW'(1) << (SUMW - 2);
                  it_ff    <= ITW'(NIT);
                  state_ff <= S_SQRT;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= S_DIFF;
               end
            end
            S_SQRT: begin
               if (acc_ff >= trial) begin
                  acc_ff  <= acc_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               it_ff  <= it_ff - 1'b1;
               if (it_ff == ITW'(1))
                  state_ff <= S_ROUND;
            end
            S_ROUND: begin
               // remainder above the root rounds the root up
               if (acc_ff > root_ff)
                  root_ff <= root_ff + 1'b1;
               state_ff <= S_DIST;
            end
            S_DIST: begin
               dist_ff  <= dist_in;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               ax_ff  <= 2'd0;
               acc_ff <= '0;
               state_ff <= S_DIFF;
               if (i_ff == hix_ff) begin
                  i_ff <= lox_ff;
                  if (j_ff == hiy_ff) begin
                     j_ff <= loy_ff;
                     if (k_ff == hiz_ff)
                        state_ff <= S_IDLE;
                     else
                        k_ff <= k_ff + 1'b1;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // reset always starts with the clearing sweep
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> state_ff == S_CLEAR)
      else $error("block does not clear after reset");

   // no transfer is taken while the memory is being swept
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("transfer accepted during clear");

   // a splat only ever lowers a stored distance
   a_min_only: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == S_CMP) |-> dist_ff < signed'(rd_data_ff))
      else $error("splat raised a cell distance");

   // a result is loaded only from a read
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RD_OUT)
      else $error("result without a read");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the particle sphere distance splat block
`timescale 1ns / 1ps
module testbench
   import psds_pkg::*;
;

   localparam int  WIDTH      = DEF_BLOCK_WIDTH;
   localparam int  FRAC       = DEF_CELL_FRAC_BITS;
   localparam int  CELLS      = WIDTH * WIDTH * WIDTH;
   localparam int  FAR_DIST   = 3 << FRAC;
   localparam int  RANDOM_ITEMS = 1780;
   localparam int  PHASES     = 8;
   // worst case: a whole-block splat visits all 512 cells
   localparam int  DRAIN_CYCLES = 20000;
   localparam longint CYCLE_LIMIT = 4_000_000;

   typedef struct {
      cmd_type              cmd;
      logic signed [15:0]   px, py, pz;
      logic [CELL_W-1:0]    cell_idx;
      bit                   typed;      // expected distance typed in below
      logic signed [15:0]   typed_dist;
   } cmd_row_type;

   typedef struct {
      logic [CELL_W-1:0]        cell_num;
      logic signed [DIST_W-1:0] dist_val;
   } cell_reading_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // shadow copy of the distance cells and registers
   logic signed [DIST_W-1:0] shadow_dist [CELLS];
   int                  shadow_radius;
   int                  shadow_search;

   cell_reading_type    pending_reads[$];
   int                  errors = 0;
   int                  n_splat = 0, n_read = 0, n_clear = 0, n_none = 0, n_checked = 0;
   longint              cycles = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   int                  last_splat_cell = 0;

   particle_sphere_distance_splat_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reads still owed", cycles, pending_reads.size());
         $display("** particle_sphere_distance_splat_top: FAILED **");
         $finish;
      end
   end

   // receiver side: random back-pressure by phase
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      errors++;
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
   endtask

   // result checker: one transfer per accepted read
   always @(posedge clock) begin
      cell_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("unexpected result, cell", -1, rsp_tdata[8:0]);
         end else begin
            want = pending_reads.pop_front();
            n_checked++;
            if (rsp_tdata[8:0] !== want.cell_num)
               report_mismatch("cell_number", want.cell_num, rsp_tdata[8:0]);
            if ($signed(rsp_tdata[24:9]) !== want.dist_val)
               report_mismatch("distance", want.dist_val, $signed(rsp_tdata[24:9]));
         end
      end
   end

   // rounded integer square root: floor root, bumped when the remainder exceeds it
   function automatic longint rounded_root(input longint unsigned s);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= s)
            r = t;
      end
      if (s - r * r > r)
         r++;
      return longint'(r);
   endfunction

   // clipped cell range of the search box on one axis
   function automatic void search_span(input int p, output int lo, output int hi);
      lo = (p - shadow_search) >>> FRAC;
      hi = (p + shadow_search) >>> FRAC;
      if (lo < 0)
         lo = 0;
      if (hi > WIDTH - 1)
         hi = WIDTH - 1;
   endfunction

   task automatic splat_into_shadow(input int px, input int py, input int pz);
      int x0, x1, y0, y1, z0, z1, idx;
      longint dx, dy, dz, d;
      search_span(px, x0, x1);
      search_span(py, y0, y1);
      search_span(pz, z0, z1);
      for (int k = z0; k <= z1; k++)
         for (int j = y0; j <= y1; j++)
            for (int i = x0; i <= x1; i++) begin
               dx = longint'((i << FRAC) + (1 << (FRAC - 1))) - px;
               dy = longint'((j << FRAC) + (1 << (FRAC - 1))) - py;
               dz = longint'((k << FRAC) + (1 << (FRAC - 1))) - pz;
               d = rounded_root(dx * dx + dy * dy + dz * dz) - shadow_radius;
               if (d > 32767)
                  d = 32767;
               if (d < -32768)
                  d = -32768;
               idx = i + WIDTH * j + WIDTH * WIDTH * k;
               if (d < shadow_dist[idx])
                  shadow_dist[idx] = 16'(d);
            end
   endtask

   // update the shadow for one accepted command and queue any result
   task automatic predict_command(input cmd_row_type r);
      cell_reading_type rd;
      case (r.cmd)
         CMD_CLEAR: begin
            n_clear++;
            foreach (shadow_dist[n])
               shadow_dist[n] = 16'(FAR_DIST);
         end
         CMD_SPLAT: begin
            n_splat++;
            splat_into_shadow(r.px, r.py, r.pz);
         end
         CMD_READ: begin
            if (r.cell_idx < CELLS) begin
               n_read++;
               rd.cell_num = r.cell_idx;
               rd.dist_val = r.typed ? r.typed_dist : shadow_dist[r.cell_idx];
               pending_reads.insert(pending_reads.size(), rd);
            end
         end
         default: n_none++;
      endcase
   endtask

   // one command transfer, with random sender gaps beforehand
   task automatic send_command(input cmd_row_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, r.cell_idx, r.pz, r.py, r.px, r.cmd};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_command(r);
   endtask

   // a read as a barrier so silent splats are done too, then every result in
   task automatic wait_quiet();
      cmd_row_type r;
      r = '{cmd: CMD_READ, px: 0, py: 0, pz: 0, cell_idx: 0, typed: 0, typed_dist: 0};
      send_command(r);
      req_tvalid <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == REG_PARTICLE_RADIUS)
         shadow_radius = value & 12'hFFF;
      else
         shadow_search = value & 12'hFFF;
   endtask

   function automatic logic signed [15:0] random_position();
      // mostly near the block, sometimes anywhere in range
      if ($urandom_range(9) == 0)
         return 16'($urandom);
      return 16'($signed($urandom_range(2304 + 512)) - 512);
   endfunction

   function automatic cmd_row_type random_command(input int splat_pct);
      cmd_row_type r;
      int pick, cx, cy, cz;
      pick = $urandom_range(99);
      r = '{cmd: CMD_READ, px: 0, py: 0, pz: 0, cell_idx: 0, typed: 0, typed_dist: 0};
      r.px = 16'($urandom);
      r.py = 16'($urandom);
      r.pz = 16'($urandom);
      r.cell_idx = CELL_W'($urandom);
      if (pick < 2) begin
         r.cmd = CMD_CLEAR;
      end else if (pick < 5) begin
         r.cmd = CMD_NONE;
      end else if (pick < 5 + splat_pct) begin
         r.cmd = CMD_SPLAT;
         r.px = random_position();
         r.py = random_position();
         r.pz = random_position();
         cx = r.px >>> FRAC;
         cy = r.py >>> FRAC;
         cz = r.pz >>> FRAC;
         if (cx >= 0 && cx < WIDTH && cy >= 0 && cy < WIDTH && cz >= 0 && cz < WIDTH)
            last_splat_cell = cx + WIDTH * cy + WIDTH * WIDTH * cz;
      end else begin
         // half the reads look at the neighborhood of a recent splat
         r.cmd = CMD_READ;
         if ($urandom_range(1))
            r.cell_idx = CELL_W'((last_splat_cell + $urandom_range(2) - 1
                      + WIDTH * ($urandom_range(2) - 1)) & (CELLS - 1));
      end
      return r;
   endfunction

   // directed commands: fixed distances only where obvious
   cmd_row_type directed [] = '{
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd0,   1, 16'sd768},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd511, 1, 16'sd768},
      '{CMD_NONE,  16'sd0,      16'sd0,      16'sd0,      9'd5,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd5,   1, 16'sd768},
      // particle exactly on the centre of cell 0 leaves minus the radius there
      '{CMD_SPLAT, 16'sd128,    16'sd128,    16'sd128,    9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd0,   1, -16'sd256},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd1,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd73,  0, 16'sd0},
      // far corners of the position range: empty search boxes
      '{CMD_SPLAT, 16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   9'd0,   0, 16'sd0},
      '{CMD_SPLAT, -16'sh8000,  -16'sh8000,  -16'sh8000,  9'd0,   0, 16'sd0},
      '{CMD_SPLAT, -16'sh8000,  16'sh7FFF,   16'sd1000,   9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd511, 1, 16'sd768},
      // top corner cell, box clipped at the far faces
      '{CMD_SPLAT, 16'sd1920,   16'sd1920,   16'sd1920,   9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd511, 1, -16'sd256},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd438, 0, 16'sd0},
      // just outside the low x and z faces, box clipped at zero
      '{CMD_SPLAT, -16'sd300,   16'sd10,     -16'sd1,     9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd8,   0, 16'sd0},
      '{CMD_CLEAR, 16'sd0,      16'sd0,      16'sd0,      9'd0,   0, 16'sd0},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd0,   1, 16'sd768},
      '{CMD_READ,  16'sd0,      16'sd0,      16'sd0,      9'd511, 1, 16'sd768},
      '{CMD_NONE,  -16'sd1,     -16'sd1,     -16'sd1,     9'd511, 0, 16'sd0}
   };

   // register settings per phase: particle radius, search half side
   int phase_radius [PHASES] = '{256,    0, 4095, 100, 4095, 0, 2048,  256};
   int phase_search [PHASES] = '{512,    0,  128, 300, 4095, 0,   64,  512};

   initial begin
      int splat_pct;
      foreach (shadow_dist[n])
         shadow_dist[n] = 16'(FAR_DIST);
      shadow_radius = RADIUS_RESET;
      shadow_search = SEARCH_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings
      foreach (directed[n])
         send_command(directed[n]);
      wait_quiet();

      for (int ph = 0; ph < PHASES; ph++) begin
         // random settings in the phase marked with zero radius after phase 1
         if (ph == 5) begin
            phase_radius[ph] = $urandom_range(4095);
            phase_search[ph] = $urandom_range(255);
         end
         write_register(REG_PARTICLE_RADIUS, phase_radius[ph]);
         write_register(REG_SEARCH_RADIUS, phase_search[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         endcase
         // keep whole-block splats rare, they visit every cell of the block
         if (shadow_search <= 256)
            splat_pct = 35;
         else if (shadow_search <= 600)
            splat_pct = 8;
         else
            splat_pct = 1;
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // sender holds off until the block has answered everything
            if (ph == 2 && n == 100) begin
               req_tvalid <= 1'b0;
               do
                  @(posedge clock);
               while (pending_reads.size() != 0);
            end
            send_command(random_command(splat_pct));
         end
         wait_quiet();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d splats, %0d reads (%0d checked), %0d clears, %0d unknown",
               n_splat, n_read, n_checked, n_clear, n_none);
      $display("over %0d register settings with idle and stall mixes", PHASES);
      if (errors == 0 && pending_reads.size() == 0) begin
         $display("** particle_sphere_distance_splat_top: PASSED **");
      end else begin
         $display("%0d mismatches, %0d reads never answered", errors, pending_reads.size());
         $display("** particle_sphere_distance_splat_top: FAILED **");
      end
      $finish;
   end

endmodule
